// ===== hw/rtl/mmo_pkg.sv =====
// mmo_pkg: shared types and constants of the min/max octree builder
// item structs, node store entry, opcodes, register indexes, fsm states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mmo_pkg;

  localparam int COORD_BITS = 9;
  localparam int AXIS_W     = 4;
  localparam int LEVEL_REG_W = 2;
  localparam int VALUE_W    = 16;
  localparam int NODE_NUM_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [1:0] OP_VOXEL = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LOG2  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LOG2  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS      = 2'd3;

  localparam logic signed [VALUE_W-1:0] EMPTY_MIN = 16'sh7fff;
  localparam logic signed [VALUE_W-1:0] EMPTY_MAX = 16'sh8000;

  typedef struct packed {
    logic [1:0]                   opcode;
    logic [COORD_BITS-1:0]        coord_x;
    logic [COORD_BITS-1:0]        coord_y;
    logic [COORD_BITS-1:0]        coord_z;
    logic signed [VALUE_W-1:0]    voxel_value;
    logic [NODE_NUM_W-1:0]        node_number;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] node_min;
    logic signed [VALUE_W-1:0] node_max;
    logic                      node_empty;
  } out_item_t;

  typedef struct packed {
    logic                      is_empty;
    logic signed [VALUE_W-1:0] max_val;
    logic signed [VALUE_W-1:0] min_val;
  } entry_t;

  localparam entry_t EMPTY_ENTRY = '{is_empty: 1'b1, max_val: EMPTY_MAX, min_val: EMPTY_MIN};

  // effective log2 axis sizes, already clamped to the coordinate width
  typedef struct packed {
    logic [AXIS_W-1:0] bits_x;
    logic [AXIS_W-1:0] bits_y;
    logic [AXIS_W-1:0] bits_z;
  } axis_cfg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mmo_ram.sv =====
// mmo_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mmo_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 585
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mmo_fold.sv =====
// mmo_fold: folds one voxel intensity into a node's min/max entry
// depends on mmo_pkg
`timescale 1ns / 1ps
`default_nettype none

module mmo_fold (
  input  wire mmo_pkg::entry_t                            old_entry,
  input  wire logic signed [mmo_pkg::VALUE_W-1:0]         value,
  output mmo_pkg::entry_t                                 new_entry
);

  // an empty entry holds the extreme values, so the compares cover it too
  always_comb begin
    new_entry.is_empty = 1'b0;
    new_entry.min_val  = (value < old_entry.min_val) ? value : old_entry.min_val;
    new_entry.max_val  = (value > old_entry.max_val) ? value : old_entry.max_val;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mmo_path.sv =====
// mmo_path: child node index along a voxel's path and the in-volume check
// depends on mmo_pkg
`timescale 1ns / 1ps
`default_nettype none

module mmo_path #(
  parameter int PATH_W = 10,
  parameter int LVL_W  = 2
) (
  input  wire mmo_pkg::axis_cfg_t                   axis,
  input  wire logic [mmo_pkg::COORD_BITS-1:0]       coord_x,
  input  wire logic [mmo_pkg::COORD_BITS-1:0]       coord_y,
  input  wire logic [mmo_pkg::COORD_BITS-1:0]       coord_z,
  input  wire logic [PATH_W-1:0]                    parent,
  input  wire logic [LVL_W-1:0]                     level,
  output logic      [PATH_W-1:0]                    child,
  output logic                                      in_volume
);

  // bit (bits - level) of the coordinate, zero when the axis is too short
  function automatic logic octant_bit(input logic [mmo_pkg::COORD_BITS-1:0] coord,
                                      input logic [mmo_pkg::AXIS_W-1:0] bits,
                                      input logic [LVL_W-1:0] lvl);
    logic [mmo_pkg::AXIS_W-1:0] sh;
    logic [mmo_pkg::COORD_BITS-1:0] shifted;
    sh = mmo_pkg::AXIS_W'(int'(bits) - int'(lvl));
    shifted = coord >> sh;
    if (int'(bits) < int'(lvl)) begin
      return 1'b0;
    end
    return shifted[0];
  endfunction

  logic [2:0] octant;

  always_comb begin
    octant[2] = octant_bit(coord_z, axis.bits_z, level);
    octant[1] = octant_bit(coord_y, axis.bits_y, level);
    octant[0] = octant_bit(coord_x, axis.bits_x, level);
    child     = PATH_W'({parent, octant}) + PATH_W'(1);
    in_volume = ((coord_x >> axis.bits_x) == '0) &&
                ((coord_y >> axis.bits_y) == '0) &&
                ((coord_z >> axis.bits_z) == '0);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/min_max_octree_builder.sv =====
// min_max_octree_builder: top level, sequencer around the node store ram
// depends on mmo_pkg, mmo_ram, mmo_path, mmo_fold
//
//   channel   direction   handshake            payload
//   in        input       in_valid / in_ready  mmo_pkg::in_item_t
//   out       output      out_valid/out_ready  mmo_pkg::out_item_t
//   cfg       input       cfg_we               cfg_addr, cfg_data
//
// voxel update: one read-modify-write per node on the path through the
// single store ram; an out-of-volume voxel is dropped without a store access
// read item: waits in ST_READ while the output register is still full
// clear item and reset: a clearing pass over all NODE_COUNT entries (585 by
// default), one entry per cycle, no item accepted meanwhile
// a waiting result does not block voxel or clear items
`timescale 1ns / 1ps
`default_nettype none

module min_max_octree_builder #(
  parameter int MAX_LEVELS = 3,
  parameter int NODE_COUNT = 585
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire mmo_pkg::in_item_t                    in_item,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output mmo_pkg::out_item_t                        out_item,
  input  wire logic                                 cfg_we,
  input  wire logic [mmo_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  wire logic [mmo_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int ADDR_W  = NODE_COUNT > 1 ? $clog2(NODE_COUNT) : 1;
  localparam int PATH_W  = 3 * MAX_LEVELS + 1;
  localparam int LVL_W   = MAX_LEVELS > 0 ? $clog2(MAX_LEVELS + 1) : 1;
  localparam int ENTRY_W = $bits(mmo_pkg::entry_t);

  // configuration registers
  logic [mmo_pkg::AXIS_W-1:0]      width_log2;
  logic [mmo_pkg::AXIS_W-1:0]      height_log2;
  logic [mmo_pkg::AXIS_W-1:0]      depth_log2;
  logic [mmo_pkg::LEVEL_REG_W-1:0] levels_in_use;

  mmo_pkg::axis_cfg_t axis;
  logic [LVL_W-1:0]   levels_eff;

  mmo_pkg::state_t state, state_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic [PATH_W-1:0] path_node, path_node_next;
  logic [LVL_W-1:0]  level, level_next;
  logic              read_oor, read_oor_next;
  logic              out_valid_next;
  mmo_pkg::out_item_t out_item_next;

  // held voxel payload
  logic [mmo_pkg::COORD_BITS-1:0]   hold_x, hold_y, hold_z;
  logic signed [mmo_pkg::VALUE_W-1:0] hold_value;
  logic                               hold_load;

  // ram ports
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  mmo_pkg::entry_t   ram_wdata, ram_rdata, folded;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  // path unit
  logic [mmo_pkg::COORD_BITS-1:0] path_x, path_y, path_z;
  logic [PATH_W-1:0]  child;
  logic               in_volume;
  logic [LVL_W-1:0]   child_level;
  logic               cur_ok, child_ok, read_in_range;

  always_comb begin
    axis.bits_x = (int'(width_log2) > mmo_pkg::COORD_BITS) ?
                  mmo_pkg::AXIS_W'(mmo_pkg::COORD_BITS) : width_log2;
    axis.bits_y = (int'(height_log2) > mmo_pkg::COORD_BITS) ?
                  mmo_pkg::AXIS_W'(mmo_pkg::COORD_BITS) : height_log2;
    axis.bits_z = (int'(depth_log2) > mmo_pkg::COORD_BITS) ?
                  mmo_pkg::AXIS_W'(mmo_pkg::COORD_BITS) : depth_log2;
    levels_eff  = (int'(levels_in_use) > MAX_LEVELS) ?
                  LVL_W'(MAX_LEVELS) : LVL_W'(levels_in_use);
  end

  // the in-volume check looks at the incoming item, the path at held coords
  assign path_x      = (state == mmo_pkg::ST_IDLE) ? in_item.coord_x : hold_x;
  assign path_y      = (state == mmo_pkg::ST_IDLE) ? in_item.coord_y : hold_y;
  assign path_z      = (state == mmo_pkg::ST_IDLE) ? in_item.coord_z : hold_z;
  assign child_level = LVL_W'(level + 1'b1);

  mmo_path #(
    .PATH_W(PATH_W),
    .LVL_W (LVL_W)
  ) u_path (
    .axis     (axis),
    .coord_x  (path_x),
    .coord_y  (path_y),
    .coord_z  (path_z),
    .parent   (path_node),
    .level    (child_level),
    .child    (child),
    .in_volume(in_volume)
  );

  assign ram_rdata = mmo_pkg::entry_t'(ram_rdata_raw);

  mmo_fold u_fold (
    .old_entry(ram_rdata),
    .value    (hold_value),
    .new_entry(folded)
  );

  mmo_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NODE_COUNT)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ENTRY_W'(ram_wdata)),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata_raw)
  );

  assign cur_ok        = 32'(path_node) < 32'(NODE_COUNT);
  assign child_ok      = 32'(child) < 32'(NODE_COUNT);
  assign read_in_range = 32'(in_item.node_number) < 32'(NODE_COUNT);

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    path_node_next = path_node;
    level_next     = level;
    read_oor_next  = read_oor;
    out_valid_next = out_valid && !out_ready;
    out_item_next  = out_item;
    hold_load      = 1'b0;
    in_ready       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = ADDR_W'(path_node);
    ram_wdata      = folded;
    ram_re         = 1'b0;
    ram_raddr      = ADDR_W'(child);

    case (state)
      mmo_pkg::ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = mmo_pkg::EMPTY_ENTRY;
        clr_addr_next = ADDR_W'(clr_addr + 1'b1);
        if (32'(clr_addr) == 32'(NODE_COUNT - 1)) begin
          state_next = mmo_pkg::ST_IDLE;
        end
      end

      mmo_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_item.opcode)
            mmo_pkg::OP_VOXEL: begin
              hold_load = 1'b1;
              if (in_volume) begin
                // root read goes out now, its write lands in the next cycle
                ram_re         = 1'b1;
                ram_raddr      = '0;
                path_node_next = '0;
                level_next     = '0;
                state_next     = mmo_pkg::ST_UPDATE;
              end
            end
            mmo_pkg::OP_READ: begin
              ram_re        = read_in_range;
              ram_raddr     = ADDR_W'(in_item.node_number);
              read_oor_next = !read_in_range;
              state_next    = mmo_pkg::ST_READ;
            end
            mmo_pkg::OP_CLEAR: begin
              clr_addr_next = '0;
              state_next    = mmo_pkg::ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end

      mmo_pkg::ST_UPDATE: begin
        // write back this node while the next node on the path is read
        ram_we = cur_ok;
        if (level < levels_eff) begin
          ram_re         = child_ok;
          path_node_next = child;
          level_next     = child_level;
        end else begin
          state_next = mmo_pkg::ST_IDLE;
        end
      end

      mmo_pkg::ST_READ: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          if (read_oor) begin
            out_item_next.node_min   = mmo_pkg::EMPTY_MIN;
            out_item_next.node_max   = mmo_pkg::EMPTY_MAX;
            out_item_next.node_empty = 1'b1;
          end else begin
            out_item_next.node_min   = ram_rdata.min_val;
            out_item_next.node_max   = ram_rdata.max_val;
            out_item_next.node_empty = ram_rdata.is_empty;
          end
          state_next = mmo_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = mmo_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mmo_pkg::ST_CLEAR;
      clr_addr      <= '0;
      out_valid     <= 1'b0;
      width_log2    <= mmo_pkg::AXIS_W'(8);
      height_log2   <= mmo_pkg::AXIS_W'(8);
      depth_log2    <= mmo_pkg::AXIS_W'(8);
      levels_in_use <= mmo_pkg::LEVEL_REG_W'(3);
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        case (cfg_addr)
          mmo_pkg::CFG_WIDTH_LOG2:  width_log2    <= cfg_data;
          mmo_pkg::CFG_HEIGHT_LOG2: height_log2   <= cfg_data;
          mmo_pkg::CFG_DEPTH_LOG2:  depth_log2    <= cfg_data;
          mmo_pkg::CFG_LEVELS:      levels_in_use <= cfg_data[mmo_pkg::LEVEL_REG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    path_node <= path_node_next;
    level     <= level_next;
    read_oor  <= read_oor_next;
    out_item  <= out_item_next;
    if (hold_load) begin
      hold_x     <= in_item.coord_x;
      hold_y     <= in_item.coord_y;
      hold_z     <= in_item.coord_z;
      hold_value <= in_item.voxel_value;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mmo_checker.sv =====
// mmo_checker: port-level assertions for min_max_octree_builder, bound to the top
// depends on mmo_pkg and min_max_octree_builder
`timescale 1ns / 1ps
`default_nettype none

module mmo_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire mmo_pkg::in_item_t              in_item,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire mmo_pkg::out_item_t             out_item
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a result waits in the output register until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped or changed while stalled");

  // reset starts the clearing pass, no item taken right after
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("item accepted during clearing pass");

  // a clear item starts a sweep that blocks the input
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_item.opcode == mmo_pkg::OP_CLEAR |=> !in_ready)
    else $error("input open right after clear item");

  // a read with a free output register shows its result through the registered ram read and the output register
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_item.opcode == mmo_pkg::OP_READ && !out_valid |=> ##1 out_valid)
    else $error("read result late");

endmodule

bind min_max_octree_builder mmo_checker u_mmo_checker (.*);

`default_nettype wire
